[design/arp_pkg.sv]
package arp_pkg;

  // Field widths fixed by the record format
  localparam int unsigned SEG_IDX_W = 4;
  localparam int unsigned CODE_W    = 8;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned BYTES_W   = 4;

  // Symbol segment that means "absolute, value zero"
  localparam logic [SEG_IDX_W-1:0] SEG_ABS = 4'd15;

  // Record sizes
  localparam logic [BYTES_W-1:0] BYTES_LOAD  = 4'd0;
  localparam logic [BYTES_W-1:0] BYTES_SHORT = 4'd8;
  localparam logic [BYTES_W-1:0] BYTES_LONG  = 4'd12;

  // Result status
  localparam logic [STATUS_W-1:0] ST_WRITTEN  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NONE     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

  // Relocation codes
  localparam logic [CODE_W-1:0] R_NONE        = 8'd0;
  localparam logic [CODE_W-1:0] R_ABS32       = 8'd2;
  localparam logic [CODE_W-1:0] R_REL32       = 8'd3;
  localparam logic [CODE_W-1:0] R_THM_CALL    = 8'd10;
  localparam logic [CODE_W-1:0] R_CALL        = 8'd28;
  localparam logic [CODE_W-1:0] R_JUMP24      = 8'd29;
  localparam logic [CODE_W-1:0] R_TARGET1     = 8'd38;
  localparam logic [CODE_W-1:0] R_V4BX        = 8'd40;
  localparam logic [CODE_W-1:0] R_TARGET2     = 8'd41;
  localparam logic [CODE_W-1:0] R_PREL31      = 8'd42;
  localparam logic [CODE_W-1:0] R_MOVW_ABS_NC = 8'd43;
  localparam logic [CODE_W-1:0] R_MOVT_ABS    = 8'd44;
  localparam logic [CODE_W-1:0] R_THM_MOVW_NC = 8'd47;
  localparam logic [CODE_W-1:0] R_THM_MOVT    = 8'd48;

  // Patch constants
  localparam logic [31:0] V4BX_KEEP   = 32'hF000_000F;
  localparam logic [31:0] V4BX_MOV    = 32'h01A0_F000;
  localparam logic [31:0] PREL31_MASK = 32'h7FFF_FFFF;
  localparam logic [31:0] THM_BIAS    = 32'h00FF_FFFF;
  localparam logic [31:0] THM_SPAN    = 32'h01FF_FFFE;
  localparam logic [31:0] ARM_BIAS    = 32'h01FF_FFFF;
  localparam logic [31:0] ARM_SPAN    = 32'h03FF_FFFE;

endpackage

[design/arp_intf.sv]
// Relocation input channel
interface arp_in_if;
  import arp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [SEG_IDX_W-1:0] seg_index;
  logic [31:0]          seg_base;
  logic [31:0]          seg_size;
  logic [31:0]          rec_word0;
  logic [31:0]          rec_word1;
  logic [31:0]          rec_word2;
  logic [31:0]          target_word;

  modport source (
    output valid, mode, seg_index, seg_base, seg_size,
           rec_word0, rec_word1, rec_word2, target_word,
    input  ready
  );
  modport sink (
    input  valid, mode, seg_index, seg_base, seg_size,
           rec_word0, rec_word1, rec_word2, target_word,
    output ready
  );
endinterface

// Patch result channel
interface arp_out_if;
  import arp_pkg::*;
  logic                valid;
  logic                ready;
  logic                write_enable;
  logic [31:0]         write_address;
  logic [31:0]         write_value;
  logic [BYTES_W-1:0]  record_bytes;
  logic [STATUS_W-1:0] status;

  modport source (
    output valid, write_enable, write_address, write_value, record_bytes, status,
    input  ready
  );
  modport sink (
    input  valid, write_enable, write_address, write_value, record_bytes, status,
    output ready
  );
endinterface

[design/arp_ram.sv]
module arp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

[design/arm_relocation_patcher.sv]
// Channel | Dir | Handshake     | Payload
// in_ch   | in  | valid / ready | mode, seg_index, seg_base, seg_size, rec_word0..2, target_word
// out_ch  | out | valid / ready | write_enable, write_address, write_value, record_bytes, status
//
// One item per cycle sustained while the output is not stalled; four register stages.
// Stages: table read + decode, address and sum, displacement, patch into output register.
// Reset clears the stage valid bits and the per-entry table valid flags; an
// unwritten table entry is masked to zero by its valid flag, so no clearing pass is needed.
// A stalled output holds its result; each stage holds while the next one is full and stalled.
module arm_relocation_patcher #(
  parameter int NUM_SEGMENTS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  arp_in_if.sink     in_ch,
  arp_out_if.source  out_ch
);
  import arp_pkg::*;

  localparam int IDX_W = $clog2(NUM_SEGMENTS);
  localparam logic [SEG_IDX_W:0] NSEG = (SEG_IDX_W+1)'(NUM_SEGMENTS);

  typedef struct packed {
    logic               mode;
    logic [BYTES_W-1:0] bytes;
    logic [CODE_W-1:0]  code;
    logic               sym_ok;
    logic               dat_ok;
    logic [31:0]        off;
    logic [31:0]        add;
    logic [31:0]        tw;
  } dec_t;

  typedef struct packed {
    logic               mode;
    logic [BYTES_W-1:0] bytes;
    logic [CODE_W-1:0]  code;
    logic               ovf;
    logic [31:0]        loc;
    logic [31:0]        sum;
    logic [31:0]        tw;
  } adr_t;

  typedef struct packed {
    logic               mode;
    logic [BYTES_W-1:0] bytes;
    logic [CODE_W-1:0]  code;
    logic               ovf;
    logic [31:0]        loc;
    logic [31:0]        sum;
    logic [31:0]        disp;
    logic [31:0]        tw;
  } dsp_t;

  // stage valids and flow control
  logic d_v_r, a_v_r, p_v_r, o_v_r;
  logic rdy_o, rdy_p, rdy_a, rdy_d, in_fire;

  assign rdy_o   = !o_v_r || out_ch.ready;
  assign rdy_p   = !p_v_r || rdy_o;
  assign rdy_a   = !a_v_r || rdy_p;
  assign rdy_d   = !d_v_r || rdy_a;
  assign in_fire = in_ch.valid && rdy_d;
  assign in_ch.ready = rdy_d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
      a_v_r <= 1'b0;
      p_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (rdy_d) d_v_r <= in_ch.valid;
      if (rdy_a) a_v_r <= d_v_r;
      if (rdy_p) p_v_r <= a_v_r;
      if (rdy_o) o_v_r <= p_v_r;
    end
  end

  // segment table: RAM plus per-entry valid flags
  logic [NUM_SEGMENTS-1:0] tv_r;
  logic                    wr_ok, tbl_we;
  logic [SEG_IDX_W-1:0]    sym_seg, dat_seg;
  logic [63:0]             rd_sym, rd_dat;

  assign wr_ok   = ({1'b0, in_ch.seg_index} < NSEG);
  assign tbl_we  = in_fire && !in_ch.mode && wr_ok;
  assign sym_seg = in_ch.rec_word0[7:4];
  assign dat_seg = in_ch.rec_word0[19:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r <= '0;
    end else if (tbl_we) begin
      tv_r[in_ch.seg_index[IDX_W-1:0]] <= 1'b1;
    end
  end

  arp_ram #(
    .WIDTH (64),
    .DEPTH (NUM_SEGMENTS)
  ) u_seg_ram (
    .clk     (clk),
    .we      (tbl_we),
    .waddr   (in_ch.seg_index[IDX_W-1:0]),
    .wdata   ({in_ch.seg_base, in_ch.seg_size}),
    .re      (rdy_d),
    .raddr_a (sym_seg[IDX_W-1:0]),
    .raddr_b (dat_seg[IDX_W-1:0]),
    .rdata_a (rd_sym),
    .rdata_b (rd_dat)
  );

  // stage 1: record decode, alongside the table read
  dec_t d_r, d_nxt;
  logic short_rec;

  always_comb begin
    short_rec    = (in_ch.rec_word0[3:0] != 4'd0);
    d_nxt.mode   = in_ch.mode;
    d_nxt.bytes  = short_rec ? BYTES_SHORT : BYTES_LONG;
    d_nxt.code   = in_ch.rec_word0[15:8];
    d_nxt.sym_ok = (sym_seg != SEG_ABS) && ({1'b0, sym_seg} < NSEG)
                   && tv_r[sym_seg[IDX_W-1:0]];
    d_nxt.dat_ok = ({1'b0, dat_seg} < NSEG) && tv_r[dat_seg[IDX_W-1:0]];
    d_nxt.off    = short_rec ? {10'd0, in_ch.rec_word1[9:0], in_ch.rec_word0[31:20]}
                             : in_ch.rec_word2;
    d_nxt.add    = short_rec ? {10'd0, in_ch.rec_word1[31:10]} : in_ch.rec_word1;
    d_nxt.tw     = in_ch.target_word;
  end

  always_ff @(posedge clk) begin
    if (rdy_d) d_r <= d_nxt;
  end

  // stage 2: target address, symbol sum, segment bound
  adr_t        a_r, a_nxt;
  logic [31:0] sym_base, dat_base, dat_size;

  always_comb begin
    sym_base    = d_r.sym_ok ? rd_sym[63:32] : 32'd0;
    dat_base    = d_r.dat_ok ? rd_dat[63:32] : 32'd0;
    dat_size    = d_r.dat_ok ? rd_dat[31:0]  : 32'd0;
    a_nxt.mode  = d_r.mode;
    a_nxt.bytes = d_r.bytes;
    a_nxt.code  = d_r.code;
    a_nxt.ovf   = ({1'b0, d_r.off} + 33'd4) > {1'b0, dat_size};
    a_nxt.loc   = dat_base + d_r.off;
    a_nxt.sum   = d_r.add + sym_base;
    a_nxt.tw    = d_r.tw;
  end

  always_ff @(posedge clk) begin
    if (rdy_a) a_r <= a_nxt;
  end

  // stage 3: PC-relative displacement
  dsp_t p_r, p_nxt;

  always_comb begin
    p_nxt.mode  = a_r.mode;
    p_nxt.bytes = a_r.bytes;
    p_nxt.code  = a_r.code;
    p_nxt.ovf   = a_r.ovf;
    p_nxt.loc   = a_r.loc;
    p_nxt.sum   = a_r.sum;
    p_nxt.disp  = a_r.sum - a_r.loc;
    p_nxt.tw    = a_r.tw;
  end

  always_ff @(posedge clk) begin
    if (rdy_p) p_r <= p_nxt;
  end

  // stage 4: patch word, range check, status
  logic                o_we_r, o_we_nxt;
  logic [31:0]         o_addr_r, o_addr_nxt;
  logic [31:0]         o_val_r, o_val_nxt;
  logic [BYTES_W-1:0]  o_bytes_r, o_bytes_nxt;
  logic [STATUS_W-1:0] o_st_r, o_st_nxt;

  logic        patch, far, sb, j1, j2;
  logic [31:0] val, imm, thm_chk, arm_chk;

  always_comb begin
    patch   = 1'b0;
    far     = 1'b0;
    val     = 32'd0;
    imm     = ((p_r.code == R_MOVT_ABS) || (p_r.code == R_THM_MOVT))
              ? {16'd0, p_r.sum[31:16]} : p_r.sum;
    thm_chk = p_r.disp + THM_BIAS;
    arm_chk = p_r.disp + ARM_BIAS;
    sb      = p_r.disp[24];
    j1      = sb ^ ~p_r.disp[23];
    j2      = sb ^ ~p_r.disp[22];

    unique case (p_r.code)
      R_NONE: begin
        patch = 1'b0;
      end
      R_V4BX: begin
        patch = 1'b1;
        val   = (p_r.tw & V4BX_KEEP) | V4BX_MOV;
      end
      R_ABS32, R_TARGET1: begin
        patch = 1'b1;
        val   = p_r.sum;
      end
      R_REL32, R_TARGET2: begin
        patch = 1'b1;
        val   = p_r.disp;
      end
      R_THM_CALL: begin
        patch = 1'b1;
        far   = thm_chk > THM_SPAN;
        val   = {p_r.tw[31:30], j1, p_r.tw[28], j2, p_r.disp[11:1],
                 p_r.tw[15:11], sb, p_r.disp[21:12]};
      end
      R_CALL, R_JUMP24: begin
        patch = 1'b1;
        far   = arm_chk > ARM_SPAN;
        val   = {p_r.tw[31:24], p_r.disp[25:2]};
      end
      R_PREL31: begin
        patch = 1'b1;
        val   = p_r.disp & PREL31_MASK;
      end
      R_MOVW_ABS_NC, R_MOVT_ABS: begin
        patch = 1'b1;
        val   = {p_r.tw[31:20], imm[15:12], p_r.tw[15:12], imm[11:0]};
      end
      R_THM_MOVW_NC, R_THM_MOVT: begin
        patch = 1'b1;
        val   = {p_r.tw[31], imm[10:8], p_r.tw[27:24], imm[7:0],
                 p_r.tw[15:11], imm[11], p_r.tw[9:4], imm[15:12]};
      end
      default: begin
        patch = 1'b0;
      end
    endcase

    o_we_nxt    = 1'b0;
    o_addr_nxt  = p_r.loc;
    o_val_nxt   = 32'd0;
    o_bytes_nxt = p_r.bytes;

    priority if (!p_r.mode) begin
      o_addr_nxt  = 32'd0;
      o_bytes_nxt = BYTES_LOAD;
      o_st_nxt    = ST_NONE;
    end else if (p_r.code == R_NONE) begin
      o_st_nxt = ST_NONE;
    end else if (!patch) begin
      o_st_nxt = ST_UNKNOWN;
    end else if (far) begin
      o_st_nxt = ST_RANGE;
    end else if (p_r.ovf) begin
      o_st_nxt = ST_OVERFLOW;
    end else begin
      o_we_nxt  = 1'b1;
      o_val_nxt = val;
      o_st_nxt  = ST_WRITTEN;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o) begin
      o_we_r    <= o_we_nxt;
      o_addr_r  <= o_addr_nxt;
      o_val_r   <= o_val_nxt;
      o_bytes_r <= o_bytes_nxt;
      o_st_r    <= o_st_nxt;
    end
  end

  assign out_ch.valid         = o_v_r;
  assign out_ch.write_enable  = o_we_r;
  assign out_ch.write_address = o_addr_r;
  assign out_ch.write_value   = o_val_r;
  assign out_ch.record_bytes  = o_bytes_r;
  assign out_ch.status        = o_st_r;

endmodule

[design/arp_checker.sv]
module arp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_write_enable,
  input logic [31:0]                   out_write_address,
  input logic [31:0]                   out_write_value,
  input logic [arp_pkg::BYTES_W-1:0]   out_record_bytes,
  input logic [arp_pkg::STATUS_W-1:0]  out_status
);
  import arp_pkg::*;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_write_address)
      && $stable(out_write_value) && $stable(out_status))
    else $error("result changed while stalled");

  // write strobe and written status go together
  a_we_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_write_enable == (out_status == ST_WRITTEN)))
    else $error("write_enable disagrees with status");

  // no write means no value
  a_val_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_enable |-> out_write_value == 32'd0)
    else $error("value without write");

  // table loads report no address and no write
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_bytes == BYTES_LOAD |->
      out_status == ST_NONE && out_write_address == 32'd0)
    else $error("bad table load result");

endmodule

bind arm_relocation_patcher arp_checker u_arp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_write_enable  (out_ch.write_enable),
  .out_write_address (out_ch.write_address),
  .out_write_value   (out_ch.write_value),
  .out_record_bytes  (out_ch.record_bytes),
  .out_status        (out_ch.status)
);

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import arp_pkg::*;

  localparam int NUM_SEGS    = 16;
  localparam int LONG_STALL  = 300;
  localparam int DRAIN       = 24;
  localparam int MAX_REPORTS = 40;
  localparam longint TIMEOUT_NS = 5_000_000;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_APPLY = 1'b1;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_style_t;

  typedef struct packed {
    logic        mode;
    logic [3:0]  seg_index;
    logic [31:0] seg_base;
    logic [31:0] seg_size;
    logic [31:0] rec_word0;
    logic [31:0] rec_word1;
    logic [31:0] rec_word2;
    logic [31:0] target_word;
  } reloc_item_t;

  typedef struct packed {
    logic                write_enable;
    logic [31:0]         write_address;
    logic [31:0]         write_value;
    logic [BYTES_W-1:0]  record_bytes;
    logic [STATUS_W-1:0] status;
  } patch_result_t;

  logic clk = 1'b0;
  logic rst_n;

  arp_in_if  in_ch ();
  arp_out_if out_ch ();

  arm_relocation_patcher #(.NUM_SEGMENTS(NUM_SEGS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor copy of the segment table, and the stimulus side's own view of it
  logic [31:0] seg_base_tbl [16];
  logic [31:0] seg_size_tbl [16];
  logic [31:0] stim_base [16];
  logic [31:0] stim_size [16];

  patch_result_t expected_patches [$];
  int          error_count;
  bit          tx_gaps_on;
  int unsigned burst_left;
  rx_style_t   rx_style;
  int          long_stalls_requested;
  int          long_stalls_served;

  // Expected outcome of one accepted item; table loads update the copy
  function automatic patch_result_t predict_patch(input reloc_item_t it);
    patch_result_t r;
    logic [31:0] off, add, sym, loc, disp, val, imm, biased;
    logic [15:0] hw1, hw2;
    logic [7:0]  code;
    logic [3:0]  symseg, datseg;
    logic        s, j1, j2;
    bit          writes;
    r.write_enable  = 1'b0;
    r.write_address = '0;
    r.write_value   = '0;
    r.record_bytes  = BYTES_LOAD;
    r.status        = ST_NONE;
    if (it.mode == MODE_LOAD) begin
      if (it.seg_index < NUM_SEGS) begin
        seg_base_tbl[it.seg_index] = it.seg_base;
        seg_size_tbl[it.seg_index] = it.seg_size;
      end
      return r;
    end
    // nonzero low nibble selects the short form
    if (it.rec_word0[3:0] != 4'h0) begin
      off = {10'h0, it.rec_word1[9:0], it.rec_word0[31:20]};
      add = {10'h0, it.rec_word1[31:10]};
      r.record_bytes = BYTES_SHORT;
    end else begin
      off = it.rec_word2;
      add = it.rec_word1;
      r.record_bytes = BYTES_LONG;
    end
    symseg = it.rec_word0[7:4];
    datseg = it.rec_word0[19:16];
    code   = it.rec_word0[15:8];
    sym = (symseg == SEG_ABS || symseg >= NUM_SEGS) ? 32'h0 : seg_base_tbl[symseg];
    loc = ((datseg < NUM_SEGS) ? seg_base_tbl[datseg] : 32'h0) + off;
    r.write_address = loc;
    hw1 = it.target_word[15:0];
    hw2 = it.target_word[31:16];
    writes = 1'b1;
    val = '0;
    case (code)
      R_NONE: begin
        writes = 1'b0;
        r.status = ST_NONE;
      end
      R_V4BX: val = (it.target_word & V4BX_KEEP) | V4BX_MOV;
      R_ABS32, R_TARGET1: val = add + sym;
      R_REL32, R_TARGET2: val = add + sym - loc;
      R_THM_CALL: begin
        disp = add + sym - loc;
        biased = disp + THM_BIAS;
        if (biased > THM_SPAN) begin
          writes = 1'b0;
          r.status = ST_RANGE;
        end else begin
          s  = disp[24];
          j1 = s ^ ~disp[23];
          j2 = s ^ ~disp[22];
          hw1 = {hw1[15:11], s, disp[21:12]};
          hw2 = {hw2[15:14], j1, hw2[12], j2, disp[11:1]};
          val = {hw2, hw1};
        end
      end
      R_CALL, R_JUMP24: begin
        disp = add + sym - loc;
        biased = disp + ARM_BIAS;
        if (biased > ARM_SPAN) begin
          writes = 1'b0;
          r.status = ST_RANGE;
        end else begin
          val = {it.target_word[31:24], disp[25:2]};
        end
      end
      R_PREL31: val = (add + sym - loc) & PREL31_MASK;
      R_MOVW_ABS_NC, R_MOVT_ABS: begin
        imm = sym + add;
        if (code == R_MOVT_ABS) imm = imm >> 16;
        val = {it.target_word[31:20], imm[15:12], it.target_word[15:12], imm[11:0]};
      end
      R_THM_MOVW_NC, R_THM_MOVT: begin
        imm = sym + add;
        if (code == R_THM_MOVT) imm = imm >> 16;
        hw1 = {hw1[15:11], imm[11], hw1[9:4], imm[15:12]};
        hw2 = {hw2[15], imm[10:8], hw2[11:8], imm[7:0]};
        val = {hw2, hw1};
      end
      default: begin
        writes = 1'b0;
        r.status = ST_UNKNOWN;
      end
    endcase
    if (writes) begin
      // end of the word compared without wrap
      if ({1'b0, off} + 33'd4 > {1'b0, (datseg < NUM_SEGS) ? seg_size_tbl[datseg] : 32'h0})
        r.status = ST_OVERFLOW;
      else begin
        r.write_enable = 1'b1;
        r.write_value  = val;
        r.status       = ST_WRITTEN;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < MAX_REPORTS)
      $display("%0t ERROR %s: got %h want %h", $time, what, got, want);
    error_count++;
  endtask

  // Input transfers feed the predictor; output transfers are checked in order
  always @(posedge clk) begin : patch_scoreboard
    reloc_item_t   seen;
    patch_result_t want;
    if (rst_n === 1'b1 && in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
      seen.mode        = in_ch.mode;
      seen.seg_index   = in_ch.seg_index;
      seen.seg_base    = in_ch.seg_base;
      seen.seg_size    = in_ch.seg_size;
      seen.rec_word0   = in_ch.rec_word0;
      seen.rec_word1   = in_ch.rec_word1;
      seen.rec_word2   = in_ch.rec_word2;
      seen.target_word = in_ch.target_word;
      expected_patches.push_back(predict_patch(seen));
    end
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_patches.size() == 0) begin
        report_mismatch("result with nothing pending", out_ch.write_address, '0);
      end else begin
        want = expected_patches.pop_front();
        if (out_ch.write_enable !== want.write_enable)
          report_mismatch("write_enable", 32'(out_ch.write_enable),
                          32'(want.write_enable));
        if (out_ch.write_address !== want.write_address)
          report_mismatch("write_address", out_ch.write_address, want.write_address);
        if (out_ch.write_value !== want.write_value)
          report_mismatch("write_value", out_ch.write_value, want.write_value);
        if (out_ch.record_bytes !== want.record_bytes)
          report_mismatch("record_bytes", 32'(out_ch.record_bytes),
                          32'(want.record_bytes));
        if (out_ch.status !== want.status)
          report_mismatch("status", 32'(out_ch.status), 32'(want.status));
      end
    end
  end

  // Result side ready: a long hold-off on request, else the current style
  initial begin : rx_ready_gen
    int unsigned cyc;
    cyc = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (long_stalls_served != long_stalls_requested) begin
        long_stalls_served++;
        out_ch.ready <= 1'b0;
        repeat (LONG_STALL - 1) @(posedge clk);
      end else begin
        case (rx_style)
          RX_ALWAYS:  out_ch.ready <= 1'b1;
          RX_RANDOM:  out_ch.ready <= ($urandom_range(0, 99) < 60);
          RX_PATTERN: out_ch.ready <= ((cyc % 9) < 5) || ($urandom_range(0, 7) == 0);
          default:    out_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  // One transfer on the input channel; returns on the edge that accepts it
  task automatic send_item(input reloc_item_t it);
    int unsigned gap;
    if (tx_gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = $urandom_range(1, 6);
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left--;
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= it.mode;
    in_ch.seg_index   <= it.seg_index;
    in_ch.seg_base    <= it.seg_base;
    in_ch.seg_size    <= it.seg_size;
    in_ch.rec_word0   <= it.rec_word0;
    in_ch.rec_word1   <= it.rec_word1;
    in_ch.rec_word2   <= it.rec_word2;
    in_ch.target_word <= it.target_word;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
  endtask

  function automatic reloc_item_t noise_item();
    reloc_item_t it;
    it.mode        = 1'($urandom_range(0, 1));
    it.seg_index   = 4'($urandom_range(0, 15));
    it.seg_base    = $urandom;
    it.seg_size    = $urandom;
    it.rec_word0   = $urandom;
    it.rec_word1   = $urandom;
    it.rec_word2   = $urandom;
    it.target_word = $urandom;
    return it;
  endfunction

  function automatic reloc_item_t make_segment_load(input logic [3:0] idx,
                                                    input logic [31:0] base,
                                                    input logic [31:0] size);
    reloc_item_t it;
    it = noise_item();
    it.mode      = MODE_LOAD;
    it.seg_index = idx;
    it.seg_base  = base;
    it.seg_size  = size;
    if (idx < NUM_SEGS) begin
      stim_base[idx] = base;
      stim_size[idx] = size;
    end
    return it;
  endfunction

  // flag zero builds a long record, any other value a short one
  function automatic reloc_item_t pack_record(input logic [3:0] flag, input logic [3:0] symseg,
                                              input logic [7:0] code, input logic [3:0] datseg,
                                              input logic [31:0] off, input logic [31:0] add,
                                              input logic [31:0] tw);
    reloc_item_t it;
    it = noise_item();
    it.mode = MODE_APPLY;
    if (flag != 4'h0) begin
      it.rec_word0 = {off[11:0], datseg, code, symseg, flag};
      it.rec_word1 = {add[21:0], off[21:12]};
    end else begin
      it.rec_word0 = {it.rec_word0[31:20], datseg, code, symseg, 4'h0};
      it.rec_word1 = add;
      it.rec_word2 = off;
    end
    it.target_word = tw;
    return it;
  endfunction

  function automatic logic [7:0] pick_known_code();
    case ($urandom_range(0, 13))
      0:  return R_NONE;
      1:  return R_ABS32;
      2:  return R_REL32;
      3:  return R_THM_CALL;
      4:  return R_CALL;
      5:  return R_JUMP24;
      6:  return R_TARGET1;
      7:  return R_V4BX;
      8:  return R_TARGET2;
      9:  return R_PREL31;
      10: return R_MOVW_ABS_NC;
      11: return R_MOVT_ABS;
      12: return R_THM_MOVW_NC;
      default: return R_THM_MOVT;
    endcase
  endfunction

  function automatic reloc_item_t random_segment_load();
    logic [31:0] base, size;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40)      base = $urandom_range(0, 32'h003F_FFFF);
    else if (roll < 80) base = $urandom;
    else                base = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF - $urandom_range(0, 4);
    roll = $urandom_range(0, 99);
    if (roll < 50)      size = $urandom_range(4, 32'h0001_0000);
    else if (roll < 70) size = $urandom;
    else begin
      case (roll % 4)
        0: size = 32'h0;
        1: size = 32'h3;
        2: size = 32'h4;
        default: size = 32'hFFFF_FFFF;
      endcase
    end
    return make_segment_load(4'($urandom_range(0, 15)), base, size);
  endfunction

  // Mostly offsets inside the segment, branches mostly aimed in range
  function automatic reloc_item_t random_record();
    logic [3:0]  flag, symseg, datseg;
    logic [7:0]  code;
    logic [31:0] size, off, add, disp, reach, sym;
    int unsigned roll;
    flag   = ($urandom_range(0, 9) < 4) ? 4'($urandom_range(1, 15)) : 4'h0;
    symseg = 4'($urandom_range(0, 15));
    datseg = 4'($urandom_range(0, 15));
    code   = ($urandom_range(0, 99) < 92) ? pick_known_code() : 8'($urandom_range(0, 255));
    size   = stim_size[datseg];
    roll   = $urandom_range(0, 99);
    if (roll < 60 && size >= 4) off = $urandom_range(0, size - 4);
    else if (roll < 80)         off = size - $urandom_range(0, 7);
    else                        off = $urandom;
    if (flag != 4'h0) off = off & 32'h003F_FFFF;
    add = $urandom;
    if ((code == R_THM_CALL || code == R_CALL || code == R_JUMP24) &&
        $urandom_range(0, 4) != 0) begin
      reach = (code == R_THM_CALL) ? THM_BIAS : ARM_BIAS;
      roll  = $urandom_range(0, 99);
      if (roll < 75) disp = $urandom_range(0, 2 * reach) - reach;
      else begin
        case (roll % 4)
          0: disp = reach;
          1: disp = reach + 1;
          2: disp = -reach;
          default: disp = -reach - 1;
        endcase
      end
      sym = (symseg == SEG_ABS) ? 32'h0 : stim_base[symseg];
      add = disp + stim_base[datseg] + off - sym;
    end
    return pack_record(flag, symseg, code, datseg, off, add, $urandom);
  endfunction

  task automatic test_table_loads();
    send_item(make_segment_load(4'd0,  32'h0000_1000, 32'h0000_2000));
    send_item(make_segment_load(4'd1,  32'h0010_0000, 32'h0001_0000));
    send_item(make_segment_load(4'd2,  32'hFFFF_FFF0, 32'hFFFF_FFFF));
    send_item(make_segment_load(4'd14, 32'hFFFF_FFFF, 32'h0000_0000));
  endtask

  // One record per supported code, plus two codes that are not known
  task automatic test_relocation_codes();
    send_item(pack_record(4'h0, 4'd1,    R_NONE,        4'd0, 32'h10,   32'h5,         $urandom));
    send_item(pack_record(4'h1, 4'd1,    R_ABS32,       4'd0, 32'h20,   32'h003F_FFFF, $urandom));
    send_item(pack_record(4'h0, SEG_ABS, R_TARGET1,     4'd0, 32'h0,    32'hFFFF_FFFF, $urandom));
    // ends exactly at the segment end
    send_item(pack_record(4'h0, 4'd1,    R_REL32,       4'd0, 32'h1FFC, 32'h0,         $urandom));
    send_item(pack_record(4'h0, 4'd2,    R_TARGET2,     4'd0, 32'h1FFD, 32'h8000_0000, $urandom));
    send_item(pack_record(4'hF, 4'd0,    R_V4BX,        4'd0, 32'h40,   32'h0,   32'hFFFF_FFFF));
    send_item(pack_record(4'h0, 4'd1,    R_THM_CALL,    4'd1, 32'h100,  32'h0,   32'hF800_F000));
    send_item(pack_record(4'h0, 4'd1,    R_CALL,        4'd0, 32'h44,   32'h0,   32'hEB00_0000));
    send_item(pack_record(4'h0, 4'd0,    R_JUMP24,      4'd1, 32'h200,  32'h0,   32'hEAFF_FFFF));
    send_item(pack_record(4'h0, 4'd2,    R_PREL31,      4'd1, 32'h8,    32'h1234,      32'h0));
    send_item(pack_record(4'h0, 4'd1,    R_MOVW_ABS_NC, 4'd0, 32'h80,   32'h0000_ABCD, 32'hFFFF_FFFF));
    send_item(pack_record(4'h0, 4'd2,    R_MOVT_ABS,    4'd0, 32'h84,   32'h1234_5678, 32'h0));
    send_item(pack_record(4'h0, 4'd1,    R_THM_MOVW_NC, 4'd0, 32'h88,   32'h0000_F8FF, 32'hFFFF_FFFF));
    send_item(pack_record(4'h0, 4'd2,    R_THM_MOVT,    4'd0, 32'h8C,   32'h8765_4321, 32'h0));
    send_item(pack_record(4'h0, 4'd1,    8'hFF,         4'd0, 32'h10,   32'h0,   32'h0));
    send_item(pack_record(4'h1, 4'd1,    8'h01,         4'd0, 32'h10,   32'h0,   32'h0));
  endtask

  // Displacements right at and just past each branch limit
  task automatic test_branch_ranges();
    send_item(pack_record(4'h0, SEG_ABS, R_THM_CALL, 4'd0, 32'h10,
                          32'h1010 + THM_BIAS, 32'hF000_F800));
    send_item(pack_record(4'h0, SEG_ABS, R_THM_CALL, 4'd0, 32'h14,
                          32'h1014 - 32'h0100_0000, 32'hF000_F800));
    send_item(pack_record(4'h0, SEG_ABS, R_CALL, 4'd0, 32'h18,
                          32'h1018 + ARM_BIAS, 32'hEB00_0000));
    send_item(pack_record(4'h0, SEG_ABS, R_JUMP24, 4'd0, 32'h1C,
                          32'h101C - 32'h0200_0000, 32'hEA00_0000));
  endtask

  task automatic test_segment_overflow();
    // empty segment at the top of memory: address wraps, write overflows
    send_item(pack_record(4'h0, SEG_ABS, R_ABS32, 4'd14, 32'h8, 32'h1, 32'h0));
    // offset near 2^32 must not wrap in the size compare
    send_item(pack_record(4'h0, 4'd0, R_ABS32, 4'd2, 32'hFFFF_FFFF, 32'h0, 32'h0));
  endtask

  task automatic test_random_mix(input int n, input bit gaps, input rx_style_t style);
    reloc_item_t it;
    int          i;
    int unsigned roll;
    tx_gaps_on = gaps;
    rx_style   = style;
    for (i = 0; i < NUM_SEGS; i++) send_item(random_segment_load());
    for (i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 7) it = random_segment_load();
      else if (roll < 10) begin
        it = noise_item();
        if (it.mode == MODE_LOAD) it = make_segment_load(it.seg_index, it.seg_base, it.seg_size);
      end else it = random_record();
      send_item(it);
    end
  endtask

  // Result side holds off while records keep coming, so the input backs up
  task automatic test_output_hold_off();
    int i;
    tx_gaps_on = 1'b0;
    rx_style   = RX_ALWAYS;
    long_stalls_requested++;
    for (i = 0; i < 40; i++) send_item(random_record());
  endtask

  initial begin : run_tests
    int i;
    error_count = 0;
    tx_gaps_on  = 1'b0;
    burst_left  = 0;
    rx_style    = RX_ALWAYS;
    long_stalls_requested = 0;
    long_stalls_served    = 0;
    for (i = 0; i < 16; i++) begin
      seg_base_tbl[i] = '0;
      seg_size_tbl[i] = '0;
      stim_base[i]    = '0;
      stim_size[i]    = '0;
    end
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.mode        <= MODE_LOAD;
    in_ch.seg_index   <= '0;
    in_ch.seg_base    <= '0;
    in_ch.seg_size    <= '0;
    in_ch.rec_word0   <= '0;
    in_ch.rec_word1   <= '0;
    in_ch.rec_word2   <= '0;
    in_ch.target_word <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_table_loads();
    test_relocation_codes();
    test_branch_ranges();
    test_segment_overflow();
    test_random_mix(590, 1'b0, RX_ALWAYS);
    test_random_mix(590, 1'b1, RX_RANDOM);
    test_output_hold_off();
    test_random_mix(560, 1'b1, RX_PATTERN);

    // drain the pipe, then a few idle cycles to catch stray results
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_patches.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin : run_limit
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[arm_relocation_patcher.f]
design/arp_pkg.sv
design/arp_intf.sv
design/arp_ram.sv
design/arm_relocation_patcher.sv
design/arp_checker.sv
dv/tb_top.sv
